[src/gocb_pkg.sv]
// Shared types, codes and arithmetic helpers for the glyph outline to cubic Bezier block.
package gocb_pkg;

    localparam int COORD_W  = 32;   // 16.16 input coordinates and 32-bit integer output coordinates
    localparam int PT_W     = 17;   // rounded integer point, -32768 .. 32768
    localparam int DIFF_W   = 19;   // twice a difference of two rounded points
    localparam int RES_W    = 19;   // rounded point plus a third of a difference
    localparam int Q_DEPTH  = 2;    // segment queue between front and back

    // Truncating divide by 3 for magnitudes below 2**21: (m * MULT) >> SHIFT
    localparam int          DIV3_SHIFT = 21;
    localparam int          MULT_W     = 20;
    localparam logic [MULT_W-1:0] DIV3_MULT = 20'd699051;

    // Input point kinds
    localparam logic [1:0] FUNC_START  = 2'd0;
    localparam logic [1:0] FUNC_LINE   = 2'd1;
    localparam logic [1:0] FUNC_SPLINE = 2'd2;
    localparam logic [1:0] FUNC_NONE   = 2'd3;

    // Output point roles
    localparam logic [1:0] ROLE_START = 2'd0;
    localparam logic [1:0] ROLE_CTRL1 = 2'd1;
    localparam logic [1:0] ROLE_CTRL2 = 2'd2;
    localparam logic [1:0] ROLE_END   = 2'd3;

    // Configuration register indexes
    localparam logic [1:0] CFG_ORIGIN_X = 2'd0;
    localparam logic [1:0] CFG_ORIGIN_Y = 2'd1;
    localparam logic [1:0] CFG_FLIP_Y   = 2'd2;

    typedef logic signed [PT_W-1:0]    pt_t;
    typedef logic signed [DIFF_W-1:0]  num_t;
    typedef logic signed [RES_W-1:0]   res_t;
    typedef logic signed [COORD_W-1:0] coord_t;

    // One queued segment: main segment A-B-C (or a start point at C),
    // plus the contour first point F for the closing line.
    typedef struct packed {
        logic is_start;
        logic is_quad;
        logic close_req;
        pt_t  ax;
        pt_t  ay;
        pt_t  bx;
        pt_t  by;
        pt_t  cx;
        pt_t  cy;
        pt_t  fx;
        pt_t  fy;
    } seg_entry_t;

    // One issued output point: base + trunc(num / 3) on each axis
    typedef struct packed {
        pt_t        base_x;
        pt_t        base_y;
        num_t       num_x;
        num_t       num_y;
        logic [1:0] role;
        logic       closing;
        logic       last;
    } pt_op_t;

    typedef struct packed {
        coord_t origin_x;
        coord_t origin_y;
        logic   flip_y;
    } cfg_t;

    // Round 16.16 half-up to an integer
    function automatic pt_t round_fx(input logic [COORD_W-1:0] f);
        round_fx = $signed({f[31], f[31:16]}) + $signed({16'b0, f[15]});
    endfunction

    // Midpoint of two 16.16 values, halved toward zero from the exact sum
    function automatic logic [COORD_W-1:0] midpoint(input logic [COORD_W-1:0] a,
                                                    input logic [COORD_W-1:0] b);
        logic [COORD_W:0] s;
        logic [COORD_W:0] t;
        s = {a[COORD_W-1], a} + {b[COORD_W-1], b};
        t = s + {{COORD_W{1'b0}}, s[COORD_W]};
        midpoint = t[COORD_W:1];
    endfunction

endpackage

[src/glyph_outline_to_cubic_bezier.sv]
// Top level of the glyph outline to cubic Bezier converter.
// Accepts one outline point per transfer (16.16 fixed point, tagged start, line or spline) and
// emits the cubic Bezier points it implies, one result per clock while output is not stalled.
// A start point gives one result, a line or quadratic piece three, and a contour end may add
// three more for the closing line; the back-end result sequencer issues them one point per
// cycle. Items that give no result (a held spline control, an undefined kind) queue no segment.
// The front end keeps accepting until two segments wait in the queue, and a result passes the
// issue, divide-by-three and output registers after its segment reaches the queue head.
// Configuration writes take effect at once and are meant for idle periods.
module glyph_outline_to_cubic_bezier (
    input  logic        clk,
    input  logic        rst_n,
    // Input points
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [63:0] s_axis_tdata,   // [31:0] x_fixed, [63:32] y_fixed
    input  logic [2:0]  s_axis_tuser,   // [1:0] func, [2] last_in_curve
    input  logic        s_axis_tlast,   // last_in_contour
    // Output points
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [63:0] m_axis_tdata,   // [31:0] out_x, [63:32] out_y
    output logic [2:0]  m_axis_tuser,   // [1:0] point_role, [2] closing
    output logic        m_axis_tlast,   // last
    // Configuration writes
    input  logic        cfg_we,
    input  logic [1:0]  cfg_addr,
    input  logic [31:0] cfg_data
);

    gocb_pkg::cfg_t        cfg_reg, cfg_next;
    gocb_pkg::seg_entry_t  push_entry;
    gocb_pkg::seg_entry_t  head_entry;
    logic                  q_push;
    logic                  q_pop;
    logic                  q_full;
    logic                  q_empty;
    logic [31:0]           out_x;
    logic [31:0]           out_y;
    logic [1:0]            point_role;
    logic                  closing;

    // Configuration register writes
    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_we)
        begin
            unique case (cfg_addr)
                gocb_pkg::CFG_ORIGIN_X: cfg_next.origin_x = cfg_data;
                gocb_pkg::CFG_ORIGIN_Y: cfg_next.origin_y = cfg_data;
                gocb_pkg::CFG_FLIP_Y:   cfg_next.flip_y   = cfg_data[0];
                default:                cfg_next          = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.origin_x <= '0;
            cfg_reg.origin_y <= '0;
            cfg_reg.flip_y   <= 1'b1;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    gocb_front u_front (
        .clk             (clk),
        .rst_n           (rst_n),
        .in_valid        (s_axis_tvalid),
        .in_ready        (s_axis_tready),
        .func            (s_axis_tuser[1:0]),
        .x_fixed         (s_axis_tdata[31:0]),
        .y_fixed         (s_axis_tdata[63:32]),
        .last_in_curve   (s_axis_tuser[2]),
        .last_in_contour (s_axis_tlast),
        .q_full          (q_full),
        .q_push          (q_push),
        .q_entry         (push_entry)
    );

    gocb_queue u_queue (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (q_push),
        .din   (push_entry),
        .pop   (q_pop),
        .dout  (head_entry),
        .full  (q_full),
        .empty (q_empty)
    );

    gocb_back u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .q_empty    (q_empty),
        .q_head     (head_entry),
        .q_pop      (q_pop),
        .cfg        (cfg_reg),
        .out_valid  (m_axis_tvalid),
        .out_ready  (m_axis_tready),
        .out_x      (out_x),
        .out_y      (out_y),
        .point_role (point_role),
        .closing    (closing),
        .last       (m_axis_tlast)
    );

    assign m_axis_tdata = {out_y, out_x};
    assign m_axis_tuser = {closing, point_role};

endmodule

[src/gocb_front.sv]
// Front end: accepts outline points, tracks contour state and queues segments.
module gocb_front (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  in_valid,
    output logic                  in_ready,
    input  logic [1:0]            func,
    input  logic [31:0]           x_fixed,
    input  logic [31:0]           y_fixed,
    input  logic                  last_in_curve,
    input  logic                  last_in_contour,
    input  logic                  q_full,
    output logic                  q_push,
    output gocb_pkg::seg_entry_t  q_entry
);

    gocb_pkg::pt_t   prev_point_x_reg, prev_point_x_next;
    gocb_pkg::pt_t   prev_point_y_reg, prev_point_y_next;
    logic [31:0]     pending_ctrl_x_reg, pending_ctrl_x_next;
    logic [31:0]     pending_ctrl_y_reg, pending_ctrl_y_next;
    logic            have_pending_reg, have_pending_next;
    gocb_pkg::pt_t   contour_first_x_reg, contour_first_x_next;
    gocb_pkg::pt_t   contour_first_y_reg, contour_first_y_next;

    logic            accept;
    logic            end_curve;
    logic            is_spline;
    logic            split;
    logic            hold;
    gocb_pkg::pt_t   rx, ry, px, py, mx, my;

    assign in_ready  = !q_full;
    assign accept    = in_valid && !q_full;
    assign end_curve = last_in_curve || last_in_contour;
    assign is_spline = (func == gocb_pkg::FUNC_SPLINE);
    assign split     = is_spline && have_pending_reg && !end_curve;
    assign hold      = is_spline && !have_pending_reg && !end_curve;

    // Round the incoming point, the held control and the implied midpoint
    assign rx = gocb_pkg::round_fx(x_fixed);
    assign ry = gocb_pkg::round_fx(y_fixed);
    assign px = gocb_pkg::round_fx(pending_ctrl_x_reg);
    assign py = gocb_pkg::round_fx(pending_ctrl_y_reg);
    assign mx = gocb_pkg::round_fx(gocb_pkg::midpoint(pending_ctrl_x_reg, x_fixed));
    assign my = gocb_pkg::round_fx(gocb_pkg::midpoint(pending_ctrl_y_reg, y_fixed));

    // Build the segment entry
    always_comb
    begin
        q_entry.is_start  = (func == gocb_pkg::FUNC_START);
        q_entry.is_quad   = is_spline && (have_pending_reg || end_curve);
        q_entry.close_req = last_in_contour;
        q_entry.ax        = prev_point_x_reg;
        q_entry.ay        = prev_point_y_reg;
        q_entry.bx        = (is_spline && have_pending_reg) ? px : rx;
        q_entry.by        = (is_spline && have_pending_reg) ? py : ry;
        q_entry.cx        = split ? mx : rx;
        q_entry.cy        = split ? my : ry;
        q_entry.fx        = q_entry.is_start ? rx : contour_first_x_reg;
        q_entry.fy        = q_entry.is_start ? ry : contour_first_y_reg;
    end

    assign q_push = accept && (func != gocb_pkg::FUNC_NONE) && !hold;

    // Advance contour state on each transfer
    always_comb
    begin
        prev_point_x_next    = prev_point_x_reg;
        prev_point_y_next    = prev_point_y_reg;
        pending_ctrl_x_next  = pending_ctrl_x_reg;
        pending_ctrl_y_next  = pending_ctrl_y_reg;
        have_pending_next    = have_pending_reg;
        contour_first_x_next = contour_first_x_reg;
        contour_first_y_next = contour_first_y_reg;
        if (accept)
        begin
            unique case (func)
                gocb_pkg::FUNC_START:
                begin
                    have_pending_next    = 1'b0;
                    prev_point_x_next    = rx;
                    prev_point_y_next    = ry;
                    contour_first_x_next = rx;
                    contour_first_y_next = ry;
                end
                gocb_pkg::FUNC_LINE:
                begin
                    have_pending_next = 1'b0;
                    prev_point_x_next = rx;
                    prev_point_y_next = ry;
                end
                gocb_pkg::FUNC_SPLINE:
                begin
                    if (hold || split)
                    begin
                        pending_ctrl_x_next = x_fixed;
                        pending_ctrl_y_next = y_fixed;
                    end
                    if (hold)
                    begin
                        have_pending_next = 1'b1;
                    end
                    else
                    begin
                        have_pending_next = split;
                        prev_point_x_next = q_entry.cx;
                        prev_point_y_next = q_entry.cy;
                    end
                end
                default:
                begin
                    // Undefined kind: drop the item
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            prev_point_x_reg    <= '0;
            prev_point_y_reg    <= '0;
            pending_ctrl_x_reg  <= '0;
            pending_ctrl_y_reg  <= '0;
            have_pending_reg    <= 1'b0;
            contour_first_x_reg <= '0;
            contour_first_y_reg <= '0;
        end
        else
        begin
            prev_point_x_reg    <= prev_point_x_next;
            prev_point_y_reg    <= prev_point_y_next;
            pending_ctrl_x_reg  <= pending_ctrl_x_next;
            pending_ctrl_y_reg  <= pending_ctrl_y_next;
            have_pending_reg    <= have_pending_next;
            contour_first_x_reg <= contour_first_x_next;
            contour_first_y_reg <= contour_first_y_next;
        end
    end

endmodule

[src/gocb_queue.sv]
// Short segment queue between the front and back ends.
module gocb_queue (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  push,
    input  gocb_pkg::seg_entry_t  din,
    input  logic                  pop,
    output gocb_pkg::seg_entry_t  dout,
    output logic                  full,
    output logic                  empty
);

    localparam int PTR_W = (gocb_pkg::Q_DEPTH > 1) ? $clog2(gocb_pkg::Q_DEPTH) : 1;
    localparam int CNT_W = $clog2(gocb_pkg::Q_DEPTH + 1);

    gocb_pkg::seg_entry_t  entries_reg [gocb_pkg::Q_DEPTH];
    logic [PTR_W-1:0]      wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0]      rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0]      count_reg, count_next;

    assign full  = (count_reg == CNT_W'(gocb_pkg::Q_DEPTH));
    assign empty = (count_reg == '0);
    assign dout  = entries_reg[rd_ptr_reg];

    // Advance pointers and occupancy
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(gocb_pkg::Q_DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(gocb_pkg::Q_DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Store the pushed segment
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entries_reg[wr_ptr_reg] <= din;
        end
    end

endmodule

[src/gocb_back.sv]
// Back end: walks queued segments, computes Bezier points and drives the output register.
module gocb_back (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  q_empty,
    input  gocb_pkg::seg_entry_t  q_head,
    output logic                  q_pop,
    input  gocb_pkg::cfg_t        cfg,
    output logic                  out_valid,
    input  logic                  out_ready,
    output logic [31:0]           out_x,
    output logic [31:0]           out_y,
    output logic [1:0]            point_role,
    output logic                  closing,
    output logic                  last
);

    logic [2:0]          idx_reg, idx_next;
    logic [2:0]          n_main;
    logic [2:0]          total;
    logic [2:0]          step_full;
    logic [1:0]          step;
    logic                need_close;
    logic                in_close;
    logic                issue;
    logic                issue_last;
    logic                en;
    logic                quad;
    gocb_pkg::pt_t       sax, say, sbx, sby, scx, scy;
    gocb_pkg::pt_op_t    op;

    gocb_pkg::pt_op_t    s1_reg;
    logic                s1_valid_reg;
    gocb_pkg::res_t      s2_x_reg, s2_y_reg;
    logic [1:0]          s2_role_reg;
    logic                s2_closing_reg;
    logic                s2_last_reg;
    logic                s2_valid_reg;
    gocb_pkg::coord_t    ext_y;
    gocb_pkg::coord_t    flip_y_val;
    logic [31:0]         out_x_reg, out_y_reg;
    logic [1:0]          out_role_reg;
    logic                out_closing_reg;
    logic                out_last_reg;
    logic                out_valid_reg;

    // Add a truncated third of num to base
    function automatic gocb_pkg::res_t third_add(input gocb_pkg::pt_t base,
                                                 input gocb_pkg::num_t num);
        logic [gocb_pkg::DIFF_W-1:0]                  mag;
        logic [gocb_pkg::DIFF_W+gocb_pkg::MULT_W-1:0] prod;
        gocb_pkg::res_t                               q;
        mag  = num[gocb_pkg::DIFF_W-1] ? -num : num;
        prod = mag * gocb_pkg::DIV3_MULT;
        q    = gocb_pkg::res_t'(prod[gocb_pkg::DIFF_W+gocb_pkg::MULT_W-1:gocb_pkg::DIV3_SHIFT]);
        third_add = gocb_pkg::res_t'(base) + (num[gocb_pkg::DIFF_W-1] ? -q : q);
    endfunction

    // Whole pipeline holds while the output register is stalled
    assign en = !out_valid_reg || out_ready;

    // Count results of the head segment
    assign n_main     = q_head.is_start ? 3'd1 : 3'd3;
    assign need_close = q_head.close_req && ((q_head.cx != q_head.fx) || (q_head.cy != q_head.fy));
    assign total      = n_main + (need_close ? 3'd3 : 3'd0);
    assign in_close   = (idx_reg >= n_main);
    assign step_full  = idx_reg - (in_close ? n_main : 3'd0);
    assign step       = step_full[1:0];
    assign issue_last = (idx_reg == total - 3'd1);
    assign issue      = en && !q_empty;
    assign q_pop      = issue && issue_last;

    // Select the active segment: main, or the closing line C -> F
    assign sax  = in_close ? q_head.cx : q_head.ax;
    assign say  = in_close ? q_head.cy : q_head.ay;
    assign sbx  = in_close ? q_head.fx : q_head.bx;
    assign sby  = in_close ? q_head.fy : q_head.by;
    assign scx  = in_close ? q_head.fx : q_head.cx;
    assign scy  = in_close ? q_head.fy : q_head.cy;
    assign quad = !in_close && q_head.is_quad;

    // Issue one point operation
    always_comb
    begin
        op         = '0;
        op.closing = in_close;
        op.last    = issue_last;
        if (q_head.is_start && !in_close)
        begin
            op.base_x = q_head.cx;
            op.base_y = q_head.cy;
            op.role   = gocb_pkg::ROLE_START;
        end
        else
        begin
            case (step)
                2'd0:
                begin
                    op.role = gocb_pkg::ROLE_CTRL1;
                    if (quad)
                    begin
                        op.base_x = sax;
                        op.base_y = say;
                        op.num_x  = (gocb_pkg::num_t'(sbx) - gocb_pkg::num_t'(sax)) <<< 1;
                        op.num_y  = (gocb_pkg::num_t'(sby) - gocb_pkg::num_t'(say)) <<< 1;
                    end
                    else
                    begin
                        op.base_x = sbx;
                        op.base_y = sby;
                    end
                end
                2'd1:
                begin
                    op.role = gocb_pkg::ROLE_CTRL2;
                    if (quad)
                    begin
                        op.base_x = sbx;
                        op.base_y = sby;
                        op.num_x  = gocb_pkg::num_t'(scx) - gocb_pkg::num_t'(sbx);
                        op.num_y  = gocb_pkg::num_t'(scy) - gocb_pkg::num_t'(sby);
                    end
                    else
                    begin
                        op.base_x = sax;
                        op.base_y = say;
                    end
                end
                default:
                begin
                    op.role   = gocb_pkg::ROLE_END;
                    op.base_x = scx;
                    op.base_y = scy;
                end
            endcase
        end
    end

    assign idx_next = issue ? (issue_last ? 3'd0 : idx_reg + 3'd1) : idx_reg;

    // Apply flip and origin for the output register
    assign ext_y      = gocb_pkg::coord_t'(s2_y_reg);
    assign flip_y_val = cfg.flip_y ? -ext_y : ext_y;

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            idx_reg       <= '0;
            s1_valid_reg  <= 1'b0;
            s2_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            idx_reg <= idx_next;
            if (en)
            begin
                s1_valid_reg  <= !q_empty;
                s2_valid_reg  <= s1_valid_reg;
                out_valid_reg <= s2_valid_reg;
            end
        end
    end

    // Payload pipeline: issue, divide-by-three, origin add
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            s1_reg          <= op;
            s2_x_reg        <= third_add(s1_reg.base_x, s1_reg.num_x);
            s2_y_reg        <= third_add(s1_reg.base_y, s1_reg.num_y);
            s2_role_reg     <= s1_reg.role;
            s2_closing_reg  <= s1_reg.closing;
            s2_last_reg     <= s1_reg.last;
            out_x_reg       <= cfg.origin_x + gocb_pkg::coord_t'(s2_x_reg);
            out_y_reg       <= cfg.origin_y + flip_y_val;
            out_role_reg    <= s2_role_reg;
            out_closing_reg <= s2_closing_reg;
            out_last_reg    <= s2_last_reg;
        end
    end

    assign out_valid  = out_valid_reg;
    assign out_x      = out_x_reg;
    assign out_y      = out_y_reg;
    assign point_role = out_role_reg;
    assign closing    = out_closing_reg;
    assign last       = out_last_reg;

    // Result index rests at zero with nothing queued
    assert property (@(posedge clk) disable iff (!rst_n)
        q_empty |-> (idx_reg == 3'd0))
        else $error("result index moved with empty queue");

    // Result index stays inside the head segment's result count
    assert property (@(posedge clk) disable iff (!rst_n)
        !q_empty |-> (idx_reg < total))
        else $error("result index past segment end");

    // A contour start point is always the only result of its item
    assert property (@(posedge clk) disable iff (!rst_n)
        (s1_valid_reg && (s1_reg.role == gocb_pkg::ROLE_START)) |->
            (s1_reg.last && !s1_reg.closing))
        else $error("start point not sole result");

endmodule
